// ===== hdl/cis_pkg.sv =====
package cis_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_CFG_W = 5;
  localparam int OUT_OFF_W = 16;
  localparam int IN_TDATA_W = 8;
  // found, match_offset, stopped_unprintable = 18 bits, padded to 3 bytes
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_MODE = 2'd3;

  localparam logic [BYTE_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

  typedef logic [BYTE_W-1:0] byte_t;

  // ASCII lower-case letters fold to upper case, nothing else changes
  function automatic byte_t fold_upper(input byte_t b);
    byte_t r;
    r = b;
    if (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) begin
      r = b & ~CASE_BIT;
    end
    return r;
  endfunction

endpackage

// ===== hdl/case_insensitive_substring_search.sv =====
// Case-insensitive substring search. Each accepted item is one byte of a
// region (tlast marks the region's final byte). The block looks for the first
// occurrence of a 1 to MAX_PATTERN byte pattern, folding ASCII a-z to A-Z on
// both sides, and gives exactly one result per region: on the byte that
// completes a match, on an unprintable byte in text mode (mode bit clear;
// printable is 0x20-0x7E plus tab), or at the last byte. Bytes after a result
// are dropped until tlast. The offset counter saturates at 2^OFFSET_BITS-1.
// Throughput is one byte per clock: the whole window compare for a byte is
// done in the cycle it is accepted and lands in the output register, so a
// result appears in the cycle after its byte. in_tready drops only while a
// result sits in the output register and out_tready is low. Configuration
// is to be written only between regions with the block idle.
module case_insensitive_substring_search #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cis_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                               in_tlast,   // last_in_region
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] found, [16:1] match_offset, [17] stopped_unprintable, [23:18] zero
  output logic [cis_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [cis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cis_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cis_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int WIN_IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  // configuration, pattern kept already folded
  byte_t                pat_r [MAX_PATTERN];
  logic [LEN_CFG_W-1:0] pat_len_r;
  logic                 bin_mode_r;

  // region state
  byte_t                win_r [MAX_PATTERN];
  byte_t                win_nxt [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;
  logic                 done_r, done_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r;
  logic [OUT_OFF_W-1:0] out_off_r;
  logic                 out_stop_r;

  logic                 acc;
  logic                 shift_en;
  logic                 emit, emit_found, emit_stop;
  logic [OUT_OFF_W-1:0] emit_off;
  logic [LEN_W-1:0]     len_eff, len_m1, pos;
  logic                 hit, printable;
  byte_t                b;

  assign in_tready = !out_valid_r || out_tready;
  assign acc = in_tvalid && in_tready;
  assign b = in_tdata[BYTE_W-1:0];

  assign out_tvalid = out_valid_r;
  assign out_tdata = {{(OUT_TDATA_W - OUT_OFF_W - 2){1'b0}}, out_stop_r, out_off_r,
                      out_found_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        pat_r[i] <= '0;
      end
      pat_len_r <= LEN_CFG_W'(1);
      bin_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_LOW: begin
          for (int i = 0; i < MAX_PATTERN && i < 8; i++) begin
            pat_r[i] <= fold_upper(cfg_data[(i & 7)*8 +: 8]);
          end
        end
        CFG_PAT_HIGH: begin
          for (int i = 8; i < MAX_PATTERN; i++) begin
            pat_r[i] <= fold_upper(cfg_data[(i & 7)*8 +: 8]);
          end
        end
        CFG_PAT_LEN:  pat_len_r <= cfg_data[LEN_CFG_W-1:0];
        CFG_BIN_MODE: bin_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (pat_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(pat_len_r) > 32'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(pat_len_r);
    end
    len_m1 = len_eff - LEN_W'(1);
  end

  assign printable = (b >= CHAR_SPACE && b <= CHAR_TILDE) || b == CHAR_TAB;

  always_comb begin
    win_nxt[0] = fold_upper(b);
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // pattern byte i lines up with window entry len-1-i (entry 0 is newest)
  always_comb begin
    hit = seen_r >= OFFSET_BITS'(len_m1);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pos = len_m1 - LEN_W'(i);
      if (LEN_W'(i) <= len_m1 && win_nxt[pos[WIN_IW-1:0]] != pat_r[i]) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    shift_en = 1'b0;
    emit = 1'b0;
    emit_found = 1'b0;
    emit_stop = 1'b0;
    emit_off = '0;
    seen_nxt = seen_r;
    done_nxt = done_r;
    if (acc) begin
      if (done_r) begin
        if (in_tlast) begin
          seen_nxt = '0;
          done_nxt = 1'b0;
        end
      end else if (!bin_mode_r && !printable) begin
        emit = 1'b1;
        emit_stop = 1'b1;
        if (in_tlast) begin
          seen_nxt = '0;
        end else begin
          done_nxt = 1'b1;
        end
      end else begin
        shift_en = 1'b1;
        if (hit) begin
          emit = 1'b1;
          emit_found = 1'b1;
          emit_off = (seen_r == OFF_MAX) ? OUT_OFF_W'(OFF_MAX)
                                         : OUT_OFF_W'(seen_r - OFFSET_BITS'(len_m1));
          if (in_tlast) begin
            seen_nxt = '0;
          end else begin
            done_nxt = 1'b1;
          end
        end else if (in_tlast) begin
          emit = 1'b1;
          seen_nxt = '0;
        end else if (seen_r != OFF_MAX) begin
          seen_nxt = seen_r + OFFSET_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_tready) begin
      out_valid_nxt = acc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      done_r <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window contents are only trusted once enough bytes of the region are in
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
    if (acc && emit) begin
      out_found_r <= emit_found;
      out_off_r <= emit_off;
      out_stop_r <= emit_stop;
    end
  end

endmodule

// ===== hdl/cis_chk.sv =====
module cis_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cis_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cis_pkg::*;

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a result is either a match or a stop, never both
  a_found_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[OUT_OFF_W+1]))
    else $error("found and stopped both set");

  // no match means a zero offset
  a_nomatch_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[OUT_OFF_W:1] == '0)
    else $error("offset set without a match");

  // with the output register empty the input side is open
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

endmodule

bind case_insensitive_substring_search cis_chk u_cis_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/case_insensitive_substring_search_tb.sv =====
`timescale 1ns / 1ps

module case_insensitive_substring_search_tb;
  import cis_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 720;
  localparam logic [15:0] SEEN_MAX = 16'hFFFF;

  typedef struct packed {
    logic        found;
    logic [15:0] offset;
    logic        stopped;
  } search_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;     // [7:0] data_byte
  logic in_tlast;                      // last_in_region
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [0] found, [16:1] match_offset, [17] stopped
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow of the block's settings and region state
  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [4:0] pat_len;
  logic bin_mode;
  byte_t window [16];
  logic [15:0] seen;
  logic region_over;

  search_result_t pending_results[$];
  byte_t region_bytes[$];

  int errors = 0;
  int quiet = 0;
  int live_items = 0;
  int n_checked = 0;
  int n_found = 0;
  int n_stopped = 0;
  int n_miss = 0;
  bit tx_idle_en = 0;
  bit rx_idle_en = 0;
  bit hold_req = 0;

  always #5 clk = ~clk;

  case_insensitive_substring_search DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic byte_t to_caps(byte_t b);
    return (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) ? (b - CASE_BIT) : b;
  endfunction

  function automatic bit is_text(byte_t b);
    return (b >= CHAR_SPACE && b <= CHAR_TILDE) || b == CHAR_TAB;
  endfunction

  // letters come back in either case, everything else unchanged
  function automatic byte_t any_case(byte_t b);
    byte_t l;
    l = b | CASE_BIT;
    if (l >= CHAR_LOW_A && l <= CHAR_LOW_Z && $urandom_range(0, 1) == 1) begin
      return b ^ CASE_BIT;
    end
    return b;
  endfunction

  function automatic int active_len();
    if (pat_len == 0) return 1;
    if (pat_len > 16) return 16;
    return int'(pat_len);
  endfunction

  function automatic byte_t pat_byte(int i);
    return (i < 8) ? pat_lo[i*8 +: 8] : pat_hi[(i-8)*8 +: 8];
  endfunction

  function automatic byte_t random_pat_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return any_case(CHAR_LOW_A + byte_t'($urandom_range(0, 25)));
    if (r < 95) return byte_t'($urandom_range(32, 126));
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic byte_t filler();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return any_case(pat_byte($urandom_range(0, active_len() - 1)));
    if (r < 92) begin
      return ($urandom_range(0, 15) == 0) ? CHAR_TAB : byte_t'($urandom_range(32, 126));
    end
    if (bin_mode) return byte_t'($urandom_range(0, 255));
    return any_case(CHAR_LOW_A + byte_t'($urandom_range(0, 25)));
  endfunction

  task automatic clear_region();
    foreach (window[i]) window[i] = '0;
    seen = '0;
    region_over = 1'b0;
  endtask

  task automatic expect_result(logic f, logic [15:0] off, logic s);
    search_result_t r;
    r.found = f;
    r.offset = off;
    r.stopped = s;
    pending_results.push_back(r);
    if (f) n_found++;
    else if (s) n_stopped++;
    else n_miss++;
  endtask

  // expected outcome of one accepted byte
  task automatic search_predict(byte_t b, logic last);
    int n;
    bit hit;
    logic [15:0] off;
    if (region_over) begin
      if (last) clear_region();
      return;
    end
    live_items++;
    // in text mode the stop test wins over a match
    if (!bin_mode && !is_text(b)) begin
      expect_result(1'b0, '0, 1'b1);
      if (last) clear_region();
      else region_over = 1'b1;
      return;
    end
    for (int i = 15; i > 0; i--) window[i] = window[i-1];
    window[0] = to_caps(b);
    n = active_len();
    hit = (seen >= n - 1);
    for (int i = 0; i < n; i++) begin
      if (window[n-1-i] != to_caps(pat_byte(i))) hit = 0;
    end
    if (hit) begin
      off = (seen == SEEN_MAX) ? SEEN_MAX : seen - 16'(n - 1);
      expect_result(1'b1, off, 1'b0);
      if (last) clear_region();
      else region_over = 1'b1;
      return;
    end
    if (seen != SEEN_MAX) seen++;
    if (last) begin
      expect_result(1'b0, '0, 1'b0);
      clear_region();
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      CFG_PAT_LOW: pat_lo = val;
      CFG_PAT_HIGH: pat_hi = val;
      CFG_PAT_LEN: pat_len = val[4:0];
      CFG_BIN_MODE: bin_mode = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_search(logic [63:0] lo, logic [63:0] hi, logic [4:0] len, logic bin);
    write_reg(CFG_PAT_LOW, lo);
    write_reg(CFG_PAT_HIGH, hi);
    write_reg(CFG_PAT_LEN, {59'd0, len});
    write_reg(CFG_BIN_MODE, {63'd0, bin});
  endtask

  task automatic send_byte(byte_t b, logic last, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tlast = last;
    do @(posedge clk); while (in_tready !== 1'b1);
    search_predict(b, last);
  endtask

  function automatic int idle_gap();
    return tx_idle_en ? $urandom_range(0, 15) : 0;
  endfunction

  task automatic send_region();
    foreach (region_bytes[i]) begin
      send_byte(region_bytes[i], i == region_bytes.size() - 1, idle_gap());
    end
  endtask

  // stop offering, let every expected result arrive, then settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tlast = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // filler around an optional pattern copy, sometimes truncated or damaged
  task automatic build_region();
    int pre;
    int post;
    int n;
    int keep;
    int bad;
    region_bytes.delete();
    pre = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    repeat (pre) region_bytes.push_back(filler());
    if ($urandom_range(0, 99) < 70) begin
      n = active_len();
      keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
      bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
      for (int j = 0; j < keep; j++) begin
        if (j == bad) region_bytes.push_back(pat_byte(j) ^ byte_t'($urandom_range(1, 255)));
        else region_bytes.push_back(any_case(pat_byte(j)));
      end
    end
    post = $urandom_range(0, 6);
    repeat (post) region_bytes.push_back(filler());
    if (region_bytes.size() == 0) region_bytes.push_back(filler());
    if ($urandom_range(0, 99) < 12) begin
      region_bytes[$urandom_range(0, region_bytes.size() - 1)] = byte_t'($urandom_range(0, 255));
    end
  endtask

  task automatic test_directed();
    // settings straight out of reset: zero byte pattern, length 1, text mode
    send_byte("a", 1'b1, 0);
    wait_idle();
    set_search(64'h4261, 64'h0, 5'd2, 1'b0);
    send_byte("x", 1'b0, 0);
    send_byte("A", 1'b0, 1);
    send_byte("b", 1'b0, 0);
    send_byte("!", 1'b1, 2);
    // tab and tilde pass, DEL stops, rest of region dropped
    send_byte(CHAR_TAB, 1'b0, 0);
    send_byte(CHAR_TILDE, 1'b0, 0);
    send_byte(8'h7F, 1'b0, 0);
    send_byte("A", 1'b1, 0);
    send_byte(8'h80, 1'b1, 0);
    send_byte(CHAR_SPACE, 1'b0, 0);
    send_byte(8'h1F, 1'b1, 0);
    wait_idle();
    // length 0 behaves as a single byte
    set_search(64'h71, 64'h0, 5'd0, 1'b0);
    send_byte("a", 1'b0, 0);
    send_byte("Q", 1'b1, 0);
    send_byte(CHAR_SPACE, 1'b0, 0);
    send_byte(CHAR_TILDE, 1'b1, 0);
    wait_idle();
    // binary mode: zero and 0xFF bytes searched literally
    set_search(64'h00FF, 64'h0, 5'd2, 1'b1);
    send_byte(8'h00, 1'b0, 0);
    send_byte(8'hFF, 1'b0, 0);
    send_byte(8'h00, 1'b1, 0);
    wait_idle();
  endtask

  task automatic test_random_regions();
    int p;
    int start;
    int nreg;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0] len;
    p = 0;
    start = live_items;
    while (live_items - start < RANDOM_ITEMS) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      case (p)
        0: set_search(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b1);
        1: set_search(64'h0, 64'h0, 5'd16, 1'b1);
        default: begin
          for (int i = 0; i < 8; i++) begin
            lo[i*8 +: 8] = random_pat_byte();
            hi[i*8 +: 8] = random_pat_byte();
          end
          case ($urandom_range(0, 7))
            0: len = 5'd0;
            1: len = 5'd1;
            2: len = 5'd2;
            3: len = 5'd16;
            4: len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(1, 16));
          endcase
          set_search(lo, hi, len, $urandom_range(0, 9) < 3);
        end
      endcase
      nreg = $urandom_range(3, 8);
      repeat (nreg) begin
        build_region();
        send_region();
      end
      wait_idle();
      p++;
    end
  endtask

  // receiver stalls for a long stretch while short regions keep coming
  task automatic test_backpressure();
    set_search(64'h78, 64'h0, 5'd1, 1'b0);
    tx_idle_en = 0;
    rx_idle_en = 0;
    hold_req = 1;
    repeat (60) begin
      send_byte(any_case(CHAR_LOW_A + byte_t'($urandom_range(0, 25))), $urandom_range(0, 1), 0);
    end
    send_byte("a", 1'b1, 0);
    wait_idle();
  endtask

  always @(posedge clk) begin
    search_result_t got;
    search_result_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got.found = out_tdata[0];
      got.offset = out_tdata[16:1];
      got.stopped = out_tdata[17];
      n_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual found %0b offset %0d stopped %0b",
                 $time, got.found, got.offset, got.stopped);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found) begin
          errors++;
          $display("%0t: found mismatch: expected %0b actual %0b",
                   $time, want.found, got.found);
        end
        if (got.offset !== want.offset) begin
          errors++;
          $display("%0t: match_offset mismatch: expected %0d actual %0d",
                   $time, want.offset, got.offset);
        end
        if (got.stopped !== want.stopped) begin
          errors++;
          $display("%0t: stopped_unprintable mismatch: expected %0b actual %0b",
                   $time, want.stopped, got.stopped);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("%0t: timeout, %0d cycles with no item moving, %0d results outstanding",
                 $time, quiet, pending_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int w;
    out_tready = 1'b0;
    forever begin
      w = rx_idle_en ? $urandom_range(0, 15) : 0;
      if (hold_req) begin
        hold_req = 0;
        w = HOLD_CYCLES;
      end
      @(negedge clk);
      if (w > 0) begin
        out_tready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PAT_LOW;
    cfg_data = '0;
    pat_lo = '0;
    pat_hi = '0;
    pat_len = 5'd1;
    bin_mode = 1'b0;
    clear_region();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_regions();
    test_backpressure();
    wait_idle();

    $display("Checked %0d results: %0d matches, %0d stops, %0d misses.",
             n_checked, n_found, n_stopped, n_miss);
    $display("Bytes searched: %0d, over text and binary modes, lengths 0 to 31 and a long stall.",
             live_items);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
